/* rtl/cpu_interrupt_entry_sequencer_macros.svh */
// Assertion macros for the interrupt entry sequencer.
// Included by modules that check their own sequencing; no other dependencies.
`ifndef CPU_INTERRUPT_ENTRY_SEQUENCER_MACROS_SVH
`define CPU_INTERRUPT_ENTRY_SEQUENCER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CIES_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CIES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/cies_pkg.sv */
// Package for the interrupt entry sequencer: field widths, vectors,
// condition code bits, request and result codes, and the frame slot order.
// No dependencies.
package cies_pkg;

    localparam int unsigned WORD_W  = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned ACK_W   = 3;
    localparam int unsigned OP_W    = 2;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned LEN_W   = 4;
    localparam int unsigned S_DATA_W = 128;
    localparam int unsigned M_DATA_W = 56;

    localparam logic [WORD_W-1:0] FIRQ_VECTOR = 16'd65526;
    localparam logic [WORD_W-1:0] IRQ_VECTOR  = 16'd65528;
    localparam logic [WORD_W-1:0] NMI_VECTOR  = 16'd65532;

    localparam logic [BYTE_W-1:0] CC_E_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] CC_F_MASK = 8'h40;
    localparam logic [BYTE_W-1:0] CC_I_MASK = 8'h10;
    localparam int unsigned CC_F_POS = 6;
    localparam int unsigned CC_I_POS = 4;

    localparam logic [LEN_W-1:0] LEN_SHORT  = 4'd3;
    localparam logic [LEN_W-1:0] LEN_FULL   = 4'd12;
    localparam logic [LEN_W-1:0] LEN_NATIVE = 4'd14;

    localparam logic [ACK_W-1:0] ACK_NONE = 3'b000;
    localparam logic [ACK_W-1:0] ACK_IRQ  = 3'b001;
    localparam logic [ACK_W-1:0] ACK_FIRQ = 3'b010;
    localparam logic [ACK_W-1:0] ACK_NMI  = 3'b100;

    localparam logic CFG_FAST_FULL = 1'b0;
    localparam logic CFG_NATIVE    = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_IRQ      = 2'd0,
        OP_FIRQ     = 2'd1,
        OP_NMI      = 2'd2,
        OP_FIRQ_RET = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE  = 2'd0,
        KIND_VECTOR = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PUSH,
        ST_VECTOR
    } state_t;

    typedef enum logic [3:0] {
        SL_PCL, SL_PCH, SL_UL, SL_UH, SL_YL, SL_YH, SL_XL, SL_XH,
        SL_DP, SL_F, SL_E, SL_B, SL_A, SL_CC
    } slot_t;

    // Push order of the frame; short frames jump from PC high to CC.
    function automatic slot_t next_slot(slot_t slot, logic full, logic native);
        slot_t nxt;
        case (slot)
            SL_PCL:  nxt = SL_PCH;
            SL_PCH:  nxt = full ? SL_UL : SL_CC;
            SL_UL:   nxt = SL_UH;
            SL_UH:   nxt = SL_YL;
            SL_YL:   nxt = SL_YH;
            SL_YH:   nxt = SL_XL;
            SL_XL:   nxt = SL_XH;
            SL_XH:   nxt = SL_DP;
            SL_DP:   nxt = native ? SL_F : SL_B;
            SL_F:    nxt = SL_E;
            SL_E:    nxt = SL_B;
            SL_B:    nxt = SL_A;
            SL_A:    nxt = SL_CC;
            default: nxt = SL_CC;
        endcase
        return nxt;
    endfunction

endpackage

/* rtl/cpu_interrupt_entry_sequencer.sv */
// Interrupt entry sequencer: one request in, stacked writes and a vector fetch, or a status, out.
// A status result is registered and valid in the cycle after acceptance; a first stack write
// follows once in the push state. An entry pushes 3, 12 or 14 bytes through the shared stack
// pointer decrementer, then a vector fetch, and only then returns to idle for the next request.
// Reset (aresetn low, synchronous) clears the sequencer, the output valid, FIRQ state and config.
// Depends on cies_pkg and cpu_interrupt_entry_sequencer_macros.svh.
module cpu_interrupt_entry_sequencer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic                          cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // prog_counter, user_stack, index_y, index_x, direct_page, acc_a, acc_b,
    // acc_e, acc_f, cond_code, sys_stack
    input  logic [cies_pkg::S_DATA_W-1:0] s_tdata,
    // operation
    input  logic [cies_pkg::OP_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // address, data, new_cond, new_stack, ack_mask, zero padding
    output logic [cies_pkg::M_DATA_W-1:0] m_tdata,
    // kind
    output logic [cies_pkg::KIND_W-1:0]   m_tuser,
    output logic                          m_tlast
);
    import cies_pkg::*;
    `include "cpu_interrupt_entry_sequencer_macros.svh"

    logic [WORD_W-1:0] in_pc, in_u, in_y, in_x, in_sp;
    logic [BYTE_W-1:0] in_dp, in_a, in_b, in_e, in_f, in_cc;
    op_t               in_op;

    assign in_pc = s_tdata[15:0];
    assign in_u  = s_tdata[31:16];
    assign in_y  = s_tdata[47:32];
    assign in_x  = s_tdata[63:48];
    assign in_dp = s_tdata[71:64];
    assign in_a  = s_tdata[79:72];
    assign in_b  = s_tdata[87:80];
    assign in_e  = s_tdata[95:88];
    assign in_f  = s_tdata[103:96];
    assign in_cc = s_tdata[111:104];
    assign in_sp = s_tdata[127:112];
    assign in_op = op_t'(s_tuser);

    state_t state_reg, state_next;
    logic   firq_active_reg, firq_active_next;
    logic   fast_full_reg, fast_full_next;
    logic   native_reg, native_next;
    slot_t  slot_reg, slot_next;
    logic   full_reg, full_next;

    logic [WORD_W-1:0] pc_reg, pc_next, u_reg, u_next, y_reg, y_next, x_reg, x_next;
    logic [BYTE_W-1:0] dp_reg, dp_next, a_reg, a_next, b_reg, b_next;
    logic [BYTE_W-1:0] e_reg, e_next, f_reg, f_next, scc_reg, scc_next;
    logic [WORD_W-1:0] sp_reg, sp_next, vec_reg, vec_next;

    logic              m_valid_reg, m_valid_next;
    kind_t             kind_reg, kind_next;
    logic [WORD_W-1:0] addr_reg, addr_next, nstack_reg, nstack_next;
    logic [BYTE_W-1:0] data_reg, data_next, ncc_reg, ncc_next;
    logic [ACK_W-1:0]  ack_reg, ack_next;
    logic              last_reg, last_next;

    logic              out_free, in_fire, push_fire;
    logic              take, full_c;
    logic [ACK_W-1:0]  ack_c;
    logic [BYTE_W-1:0] scc_c, fcc_c, byte_c;
    logic [WORD_W-1:0] vec_c, sp_dec;
    logic [LEN_W-1:0]  len_c;

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign in_fire   = s_tvalid && s_tready;
    assign push_fire = (state_reg == ST_PUSH) && out_free;
    assign sp_dec    = sp_reg - WORD_W'(1);

    always_comb begin
        take  = 1'b1;
        full_c = 1'b1;
        ack_c = ACK_NONE;
        scc_c = in_cc | CC_E_MASK;
        fcc_c = scc_c | CC_I_MASK | CC_F_MASK;
        vec_c = NMI_VECTOR;
        case (in_op)
            OP_FIRQ_RET: begin
                take = 1'b0;
            end
            OP_IRQ: begin
                if (firq_active_reg) begin
                    take = 1'b0;
                end else if (in_cc[CC_I_POS]) begin
                    take  = 1'b0;
                    ack_c = ACK_IRQ;
                end else begin
                    ack_c = ACK_IRQ;
                    fcc_c = scc_c | CC_I_MASK;
                    vec_c = IRQ_VECTOR;
                end
            end
            OP_FIRQ: begin
                ack_c = ACK_FIRQ;
                if (in_cc[CC_F_POS]) begin
                    take = 1'b0;
                end else begin
                    full_c = fast_full_reg;
                    scc_c  = fast_full_reg ? (in_cc | CC_E_MASK) : (in_cc & ~CC_E_MASK);
                    fcc_c  = scc_c | CC_I_MASK | CC_F_MASK;
                    vec_c  = FIRQ_VECTOR;
                end
            end
            default: begin
                ack_c = ACK_NMI;
            end
        endcase
        if (!full_c) begin
            len_c = LEN_SHORT;
        end else if (native_reg) begin
            len_c = LEN_NATIVE;
        end else begin
            len_c = LEN_FULL;
        end
    end

    always_comb begin
        case (slot_reg)
            SL_PCL:  byte_c = pc_reg[7:0];
            SL_PCH:  byte_c = pc_reg[15:8];
            SL_UL:   byte_c = u_reg[7:0];
            SL_UH:   byte_c = u_reg[15:8];
            SL_YL:   byte_c = y_reg[7:0];
            SL_YH:   byte_c = y_reg[15:8];
            SL_XL:   byte_c = x_reg[7:0];
            SL_XH:   byte_c = x_reg[15:8];
            SL_DP:   byte_c = dp_reg;
            SL_F:    byte_c = f_reg;
            SL_E:    byte_c = e_reg;
            SL_B:    byte_c = b_reg;
            SL_A:    byte_c = a_reg;
            default: byte_c = scc_reg;
        endcase
    end

    always_comb begin
        state_next       = state_reg;
        firq_active_next = firq_active_reg;
        fast_full_next   = fast_full_reg;
        native_next      = native_reg;
        slot_next        = slot_reg;
        full_next        = full_reg;
        pc_next  = pc_reg;
        u_next   = u_reg;
        y_next   = y_reg;
        x_next   = x_reg;
        dp_next  = dp_reg;
        a_next   = a_reg;
        b_next   = b_reg;
        e_next   = e_reg;
        f_next   = f_reg;
        scc_next = scc_reg;
        sp_next  = sp_reg;
        vec_next = vec_reg;
        m_valid_next = m_valid_reg && !m_tready;
        kind_next    = kind_reg;
        addr_next    = addr_reg;
        data_next    = data_reg;
        ncc_next     = ncc_reg;
        nstack_next  = nstack_reg;
        ack_next     = ack_reg;
        last_next    = last_reg;

        if (cfg_we) begin
            if (cfg_index == CFG_FAST_FULL) begin
                fast_full_next = cfg_wdata;
            end else begin
                native_next = cfg_wdata;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    ack_next = ack_c;
                    if (in_op == OP_FIRQ_RET) begin
                        firq_active_next = 1'b0;
                    end
                    if (take) begin
                        if (in_op == OP_FIRQ) begin
                            firq_active_next = 1'b1;
                        end
                        state_next  = ST_PUSH;
                        slot_next   = SL_PCL;
                        full_next   = full_c;
                        pc_next     = in_pc;
                        u_next      = in_u;
                        y_next      = in_y;
                        x_next      = in_x;
                        dp_next     = in_dp;
                        a_next      = in_a;
                        b_next      = in_b;
                        e_next      = in_e;
                        f_next      = in_f;
                        scc_next    = scc_c;
                        sp_next     = in_sp;
                        vec_next    = vec_c;
                        ncc_next    = fcc_c;
                        nstack_next = in_sp - {{(WORD_W-LEN_W){1'b0}}, len_c};
                    end else begin
                        m_valid_next = 1'b1;
                        kind_next    = KIND_STATUS;
                        addr_next    = '0;
                        data_next    = '0;
                        ncc_next     = in_cc;
                        nstack_next  = in_sp;
                        last_next    = 1'b1;
                    end
                end
            end
            ST_PUSH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    kind_next    = KIND_WRITE;
                    addr_next    = sp_dec;
                    data_next    = byte_c;
                    last_next    = 1'b0;
                    sp_next      = sp_dec;
                    if (slot_reg == SL_CC) begin
                        state_next = ST_VECTOR;
                    end else begin
                        slot_next = next_slot(slot_reg, full_reg, native_reg);
                    end
                end
            end
            ST_VECTOR: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    kind_next    = KIND_VECTOR;
                    addr_next    = vec_reg;
                    data_next    = '0;
                    last_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            firq_active_reg <= 1'b0;
            fast_full_reg   <= 1'b0;
            native_reg      <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            firq_active_reg <= firq_active_next;
            fast_full_reg   <= fast_full_next;
            native_reg      <= native_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg   <= slot_next;
        full_reg   <= full_next;
        pc_reg     <= pc_next;
        u_reg      <= u_next;
        y_reg      <= y_next;
        x_reg      <= x_next;
        dp_reg     <= dp_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        e_reg      <= e_next;
        f_reg      <= f_next;
        scc_reg    <= scc_next;
        sp_reg     <= sp_next;
        vec_reg    <= vec_next;
        kind_reg   <= kind_next;
        addr_reg   <= addr_next;
        data_reg   <= data_next;
        ncc_reg    <= ncc_next;
        nstack_reg <= nstack_next;
        ack_reg    <= ack_next;
        last_reg   <= last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {5'b0, ack_reg, nstack_reg, ncc_reg, data_reg, addr_reg};

    `CIES_ASSERT_NEXT(a_entry_starts_push, in_fire && take, state_reg == ST_PUSH,
        "A taken entry did not start the push sequence.")
    `CIES_ASSERT_NEXT(a_push_addr_tracks_sp, push_fire,
        m_valid_reg && kind_reg == KIND_WRITE && addr_reg == sp_reg,
        "A stack write address does not match the stack pointer.")
    `CIES_ASSERT_SAME(a_frame_length, state_reg == ST_VECTOR, sp_reg == nstack_reg,
        "The pushed frame length does not match the final stack pointer.")
    `CIES_ASSERT_SAME(a_last_on_final, m_valid_reg && kind_reg != KIND_WRITE, last_reg,
        "A vector or status result is not marked as the last of its request.")

endmodule
